FILE: src/rzpb_pkg.sv
// ----------------------------------------------------------------------------
// rzpb_pkg
// Shared widths, register codes, types and helpers for the rectangle zone
// particle bounce block.
// ----------------------------------------------------------------------------
`default_nettype none

package rzpb_pkg;

    // Field widths
    localparam int COORD_W  = 24;              // signed Q15.8 coordinate
    localparam int DIM_W    = 23;              // unsigned Q15.8 size / margin
    localparam int EXT_W    = COORD_W + 2;     // bound sums: left + width - margin
    localparam int MAG_W    = COORD_W + 1;     // distance magnitude to the rectangle
    localparam int SQ_W     = 2 * MAG_W;       // squared distance per axis
    localparam int SUM_W    = SQ_W + 1;        // dx^2 + dy^2
    localparam int MSQ_W    = 2 * DIM_W;       // margin^2

    // Stream widths
    localparam int IN_DATA_W  = 6 * COORD_W;   // 144 bits, whole bytes
    localparam int OUT_DATA_W = 4 * COORD_W;   // 96 bits, whole bytes
    localparam int OUT_USER_W = 3;

    // Configuration port
    localparam int APB_ADDR_W = 5;
    localparam int APB_DATA_W = 32;
    localparam int REG_IDX_W  = 3;

    localparam logic [REG_IDX_W-1:0] REG_ZONE_LEFT   = 3'd0;
    localparam logic [REG_IDX_W-1:0] REG_ZONE_TOP    = 3'd1;
    localparam logic [REG_IDX_W-1:0] REG_ZONE_WIDTH  = 3'd2;
    localparam logic [REG_IDX_W-1:0] REG_ZONE_HEIGHT = 3'd3;
    localparam logic [REG_IDX_W-1:0] REG_EDGE_MARGIN = 3'd4;
    localparam logic [REG_IDX_W-1:0] REG_STAY_INSIDE = 3'd5;

    // Pipeline: input register, three compute stages, output register
    localparam int NUM_STAGES = 5;

    typedef logic signed [COORD_W-1:0] t_coord;
    typedef logic        [DIM_W-1:0]   t_dim;
    typedef logic signed [EXT_W-1:0]   t_ext;
    typedef logic        [MAG_W-1:0]   t_mag;
    typedef logic        [SQ_W-1:0]    t_sq;

    localparam t_coord COORD_MAX = 24'sh7FFFFF;
    localparam t_coord COORD_MIN = 24'sh800000;

    typedef struct packed {
        t_coord pos_x;
        t_coord pos_y;
        t_coord vel_x;
        t_coord vel_y;
        t_coord prev_x;
        t_coord prev_y;
    } t_particle;

    // Per-axis placement of one coordinate against the zone
    typedef struct packed {
        logic in_inset;   // within the margin-inset span, closed
        logic below;      // before the rectangle's low edge
        logic above;      // past the rectangle's high edge
    } t_axis_pos;

    // Sign-extend a coordinate to bound width
    function automatic t_ext ext_coord(input t_coord v);
        return t_ext'(v);
    endfunction

    // Zero-extend a size to bound width
    function automatic t_ext ext_dim(input t_dim v);
        return t_ext'({1'b0, v});
    endfunction

    // Negate with saturation of the most negative value
    function automatic t_coord neg_sat(input t_coord v);
        if (v == COORD_MIN) begin
            return COORD_MAX;
        end else begin
            return -v;
        end
    endfunction

endpackage

`default_nettype wire

FILE: src/rect_zone_particle_bounce.sv
// ----------------------------------------------------------------------------
// rect_zone_particle_bounce
// Bounces particles off a configured axis-aligned rectangle, either keeping
// them inside the margin-inset zone or outside a margin-wide halo.
// ----------------------------------------------------------------------------
// Throughput is one particle per clock while the output is not stalled. A
// particle's result passes from the input register through each later
// register, that is three compute stages (bound compares, edge distances,
// squares) and the output register. Ready on the input drops only when the
// output is stalled and every stage holds a particle. Per-axis collision
// resolution reverts the offending axis to its previous coordinate and
// negates (saturating) its velocity. Registers are at byte addresses 0x00
// left, 0x04 top, 0x08 width, 0x0C height, 0x10 margin, 0x14 stay-inside;
// write them only while no particle is in flight.
`default_nettype none

module rect_zone_particle_bounce
    import rzpb_pkg::*;
(
    input  wire                    i_clk,
    input  wire                    i_rst_n,

    // Particle request input
    input  wire                    i_s_axis_tvalid,
    output logic                   o_s_axis_tready,
    // [23:0] pos_x, [47:24] pos_y, [71:48] vel_x, [95:72] vel_y,
    // [119:96] prev_x, [143:120] prev_y
    input  wire [IN_DATA_W-1:0]    i_s_axis_tdata,

    // Resolved particle output
    output logic                   o_m_axis_tvalid,
    input  wire                    i_m_axis_tready,
    // [23:0] out_pos_x, [47:24] out_pos_y, [71:48] out_vel_x, [95:72] out_vel_y
    output logic [OUT_DATA_W-1:0]  o_m_axis_tdata,
    // [0] collided, [1] inside_inset, [2] near_zone
    output logic [OUT_USER_W-1:0]  o_m_axis_tuser,

    // Configuration port
    input  wire                    psel,
    input  wire                    penable,
    input  wire                    pwrite,
    input  wire [APB_ADDR_W-1:0]   paddr,
    input  wire [APB_DATA_W-1:0]   pwdata,
    output logic [APB_DATA_W-1:0]  prdata,
    output logic                   pready
);

    // ------------------------------------------------------------------
    // Configuration registers
    // ------------------------------------------------------------------
    t_coord r_zone_left;
    t_coord r_zone_top;
    t_dim   r_zone_width;
    t_dim   r_zone_height;
    t_dim   r_edge_margin;
    logic   r_stay_inside;

    logic                 w_cfg_wr;
    logic [REG_IDX_W-1:0] w_cfg_idx;

    assign pready    = 1'b1;
    assign w_cfg_wr  = psel & penable & pwrite & pready;
    assign w_cfg_idx = paddr[APB_ADDR_W-1:2];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_zone_left   <= '0;
            r_zone_top    <= '0;
            r_zone_width  <= '0;
            r_zone_height <= '0;
            r_edge_margin <= '0;
            r_stay_inside <= 1'b1;
        end else if (w_cfg_wr) begin
            unique case (w_cfg_idx)
                REG_ZONE_LEFT:   r_zone_left   <= pwdata[COORD_W-1:0];
                REG_ZONE_TOP:    r_zone_top    <= pwdata[COORD_W-1:0];
                REG_ZONE_WIDTH:  r_zone_width  <= pwdata[DIM_W-1:0];
                REG_ZONE_HEIGHT: r_zone_height <= pwdata[DIM_W-1:0];
                REG_EDGE_MARGIN: r_edge_margin <= pwdata[DIM_W-1:0];
                REG_STAY_INSIDE: r_stay_inside <= pwdata[0];
                default: ;
            endcase
        end
    end

    // Register readback
    always_comb begin
        unique case (w_cfg_idx)
            REG_ZONE_LEFT:   prdata = APB_DATA_W'({r_zone_left});
            REG_ZONE_TOP:    prdata = APB_DATA_W'({r_zone_top});
            REG_ZONE_WIDTH:  prdata = APB_DATA_W'(r_zone_width);
            REG_ZONE_HEIGHT: prdata = APB_DATA_W'(r_zone_height);
            REG_EDGE_MARGIN: prdata = APB_DATA_W'(r_edge_margin);
            REG_STAY_INSIDE: prdata = APB_DATA_W'(r_stay_inside);
            default:         prdata = '0;
        endcase
    end

    // ------------------------------------------------------------------
    // Pipeline flow control: a stage loads when empty or when it drains
    // ------------------------------------------------------------------
    logic [NUM_STAGES-1:0] r_v;
    logic [NUM_STAGES-1:0] w_rdy;

    always_comb begin
        w_rdy[NUM_STAGES-1] = !r_v[NUM_STAGES-1] || i_m_axis_tready;
        for (int k = NUM_STAGES - 2; k >= 0; k--) begin
            w_rdy[k] = !r_v[k] || w_rdy[k+1];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v <= '0;
        end else begin
            if (w_rdy[0]) begin
                r_v[0] <= i_s_axis_tvalid;
            end
            for (int k = 1; k < NUM_STAGES; k++) begin
                if (w_rdy[k]) begin
                    r_v[k] <= r_v[k-1];
                end
            end
        end
    end

    assign o_s_axis_tready = w_rdy[0];
    assign o_m_axis_tvalid = r_v[NUM_STAGES-1];

    // ------------------------------------------------------------------
    // Stage 0: input register
    // ------------------------------------------------------------------
    t_particle r0_p;

    always_ff @(posedge i_clk) begin
        if (w_rdy[0]) begin
            r0_p.pos_x  <= i_s_axis_tdata[0*COORD_W +: COORD_W];
            r0_p.pos_y  <= i_s_axis_tdata[1*COORD_W +: COORD_W];
            r0_p.vel_x  <= i_s_axis_tdata[2*COORD_W +: COORD_W];
            r0_p.vel_y  <= i_s_axis_tdata[3*COORD_W +: COORD_W];
            r0_p.prev_x <= i_s_axis_tdata[4*COORD_W +: COORD_W];
            r0_p.prev_y <= i_s_axis_tdata[5*COORD_W +: COORD_W];
        end
    end

    // ------------------------------------------------------------------
    // Zone bounds from configuration
    // ------------------------------------------------------------------
    t_ext w_x_lo, w_x_hi, w_xi_lo, w_xi_hi;
    t_ext w_y_lo, w_y_hi, w_yi_lo, w_yi_hi;

    assign w_x_lo  = ext_coord(r_zone_left);
    assign w_x_hi  = w_x_lo + ext_dim(r_zone_width);
    assign w_xi_lo = w_x_lo + ext_dim(r_edge_margin);
    assign w_xi_hi = w_x_hi - ext_dim(r_edge_margin);
    assign w_y_lo  = ext_coord(r_zone_top);
    assign w_y_hi  = w_y_lo + ext_dim(r_zone_height);
    assign w_yi_lo = w_y_lo + ext_dim(r_edge_margin);
    assign w_yi_hi = w_y_hi - ext_dim(r_edge_margin);

    // ------------------------------------------------------------------
    // Stage 1: place each coordinate against the zone edges
    // ------------------------------------------------------------------
    t_particle r1_p;
    t_axis_pos r1_xp, r1_xq, r1_yp, r1_yq;   // p: new coordinate, q: previous
    t_axis_pos w_xp, w_xq, w_yp, w_yq;

    always_comb begin
        w_xp.in_inset = ext_coord(r0_p.pos_x) >= w_xi_lo && ext_coord(r0_p.pos_x) <= w_xi_hi;
        w_xp.below    = ext_coord(r0_p.pos_x) <  w_x_lo;
        w_xp.above    = ext_coord(r0_p.pos_x) >  w_x_hi;
        w_xq.in_inset = ext_coord(r0_p.prev_x) >= w_xi_lo && ext_coord(r0_p.prev_x) <= w_xi_hi;
        w_xq.below    = ext_coord(r0_p.prev_x) <  w_x_lo;
        w_xq.above    = ext_coord(r0_p.prev_x) >  w_x_hi;
        w_yp.in_inset = ext_coord(r0_p.pos_y) >= w_yi_lo && ext_coord(r0_p.pos_y) <= w_yi_hi;
        w_yp.below    = ext_coord(r0_p.pos_y) <  w_y_lo;
        w_yp.above    = ext_coord(r0_p.pos_y) >  w_y_hi;
        w_yq.in_inset = ext_coord(r0_p.prev_y) >= w_yi_lo && ext_coord(r0_p.prev_y) <= w_yi_hi;
        w_yq.below    = ext_coord(r0_p.prev_y) <  w_y_lo;
        w_yq.above    = ext_coord(r0_p.prev_y) >  w_y_hi;
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[1]) begin
            r1_p  <= r0_p;
            r1_xp <= w_xp;
            r1_xq <= w_xq;
            r1_yp <= w_yp;
            r1_yq <= w_yq;
        end
    end

    // ------------------------------------------------------------------
    // Stage 2: distance to the rectangle per axis, negated velocities
    // ------------------------------------------------------------------
    t_particle r2_p;
    logic      r2_ixp, r2_ixq, r2_iyp, r2_iyq;
    t_mag      r2_axp, r2_axq, r2_ayp, r2_ayq;
    t_coord    r2_nvx, r2_nvy;

    t_ext w_dxp, w_dxq, w_dyp, w_dyq;

    always_comb begin
        // Edge distance: lo - c when below, c - hi when above, else zero
        if (r1_xp.below) begin
            w_dxp = w_x_lo - ext_coord(r1_p.pos_x);
        end else if (r1_xp.above) begin
            w_dxp = ext_coord(r1_p.pos_x) - w_x_hi;
        end else begin
            w_dxp = '0;
        end
        if (r1_xq.below) begin
            w_dxq = w_x_lo - ext_coord(r1_p.prev_x);
        end else if (r1_xq.above) begin
            w_dxq = ext_coord(r1_p.prev_x) - w_x_hi;
        end else begin
            w_dxq = '0;
        end
        if (r1_yp.below) begin
            w_dyp = w_y_lo - ext_coord(r1_p.pos_y);
        end else if (r1_yp.above) begin
            w_dyp = ext_coord(r1_p.pos_y) - w_y_hi;
        end else begin
            w_dyp = '0;
        end
        if (r1_yq.below) begin
            w_dyq = w_y_lo - ext_coord(r1_p.prev_y);
        end else if (r1_yq.above) begin
            w_dyq = ext_coord(r1_p.prev_y) - w_y_hi;
        end else begin
            w_dyq = '0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_rdy[2]) begin
            r2_p   <= r1_p;
            r2_ixp <= r1_xp.in_inset;
            r2_ixq <= r1_xq.in_inset;
            r2_iyp <= r1_yp.in_inset;
            r2_iyq <= r1_yq.in_inset;
            r2_axp <= w_dxp[MAG_W-1:0];
            r2_axq <= w_dxq[MAG_W-1:0];
            r2_ayp <= w_dyp[MAG_W-1:0];
            r2_ayq <= w_dyq[MAG_W-1:0];
            r2_nvx <= neg_sat(r1_p.vel_x);
            r2_nvy <= neg_sat(r1_p.vel_y);
        end
    end

    // ------------------------------------------------------------------
    // Stage 3: squares
    // ------------------------------------------------------------------
    t_particle          r3_p;
    logic               r3_ixp, r3_ixq, r3_iyp, r3_iyq;
    t_sq                r3_sxp, r3_sxq, r3_syp, r3_syq;
    logic [MSQ_W-1:0]   r3_m2;
    t_coord             r3_nvx, r3_nvy;

    always_ff @(posedge i_clk) begin
        if (w_rdy[3]) begin
            r3_p   <= r2_p;
            r3_ixp <= r2_ixp;
            r3_ixq <= r2_ixq;
            r3_iyp <= r2_iyp;
            r3_iyq <= r2_iyq;
            r3_sxp <= r2_axp * r2_axp;
            r3_sxq <= r2_axq * r2_axq;
            r3_syp <= r2_ayp * r2_ayp;
            r3_syq <= r2_ayq * r2_ayq;
            r3_m2  <= r_edge_margin * r_edge_margin;
            r3_nvx <= r2_nvx;
            r3_nvy <= r2_nvy;
        end
    end

    // ------------------------------------------------------------------
    // Stage 4: validity tests, per-axis resolution, output register
    // ------------------------------------------------------------------
    logic [SUM_W-1:0] w_d2_pp, w_d2_xo, w_d2_yo, w_m2;
    logic w_near_pp, w_near_xo, w_near_yo;
    logic w_ok, w_xok, w_yok, w_rev_x, w_rev_y;

    always_comb begin
        w_m2    = SUM_W'(r3_m2);
        // new position, x-only move (new x, prev y), y-only move (prev x, new y)
        w_d2_pp = SUM_W'(r3_sxp) + SUM_W'(r3_syp);
        w_d2_xo = SUM_W'(r3_sxp) + SUM_W'(r3_syq);
        w_d2_yo = SUM_W'(r3_sxq) + SUM_W'(r3_syp);
        w_near_pp = w_d2_pp < w_m2;
        w_near_xo = w_d2_xo < w_m2;
        w_near_yo = w_d2_yo < w_m2;
        w_ok  = r_stay_inside ? (r3_ixp & r3_iyp) : !w_near_pp;
        w_xok = r_stay_inside ? (r3_ixp & r3_iyq) : !w_near_xo;
        w_yok = r_stay_inside ? (r3_ixq & r3_iyp) : !w_near_yo;
        // revert an axis whose lone move fails; both if both lone moves pass
        w_rev_x = !w_ok && (!w_xok || w_yok);
        w_rev_y = !w_ok && (!w_yok || w_xok);
    end

    t_coord r4_pos_x, r4_pos_y, r4_vel_x, r4_vel_y;
    logic   r4_collided, r4_inside, r4_near;

    always_ff @(posedge i_clk) begin
        if (w_rdy[4]) begin
            r4_pos_x    <= w_rev_x ? r3_p.prev_x : r3_p.pos_x;
            r4_vel_x    <= w_rev_x ? r3_nvx      : r3_p.vel_x;
            r4_pos_y    <= w_rev_y ? r3_p.prev_y : r3_p.pos_y;
            r4_vel_y    <= w_rev_y ? r3_nvy      : r3_p.vel_y;
            r4_collided <= !w_ok;
            r4_inside   <= r3_ixp & r3_iyp;
            r4_near     <= w_near_pp;
        end
    end

    assign o_m_axis_tdata = {r4_vel_y, r4_vel_x, r4_pos_y, r4_pos_x};
    assign o_m_axis_tuser = {r4_near, r4_inside, r4_collided};

    // ------------------------------------------------------------------
    // Checks
    // ------------------------------------------------------------------
`ifndef SYNTHESIS
    // an empty output stage never back-pressures the input
    a_ready_when_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !r_v[NUM_STAGES-1] |-> o_s_axis_tready)
        else $error("input stalled with output stage empty");

    // an accepted request occupies the input stage next cycle
    a_accept_loads: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_s_axis_tvalid && o_s_axis_tready) |=> r_v[0])
        else $error("accepted request lost at input stage");

    // output stage takes exactly what the last compute stage held
    a_out_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_rdy[NUM_STAGES-1] |=> (r_v[NUM_STAGES-1] == $past(r_v[NUM_STAGES-2])))
        else $error("result created or dropped at output stage");

    // mode register write lands
    a_mode_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (w_cfg_wr && w_cfg_idx == REG_STAY_INSIDE) |=> (r_stay_inside == $past(pwdata[0])))
        else $error("stay-inside write not applied");
`endif

endmodule

`default_nettype wire

FILE: sim/tb_rect_zone_particle_bounce.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// tb_rect_zone_particle_bounce
// Self-checking bench for the rectangle zone particle bounce block. Particles
// go in on the input stream, and a local bounce predictor computes the
// resolved particle for each request against its own copy of the zone
// registers. The output stream is checked field by field, in order. Directed
// requests cover the reset zone, stay-inside and keep-out edges, the empty
// inset, the zero margin, saturating negation and register masking. Random
// traffic then runs under several zone settings and handshake idling mixes.
// ----------------------------------------------------------------------------

module tb_rect_zone_particle_bounce;
    import rzpb_pkg::*;

    localparam int WATCHDOG_LIMIT = 4000;

    // Register indexes past the end of the map; writes there must be ignored
    localparam logic [REG_IDX_W-1:0] REG_SPARE_LO = 3'd6;
    localparam logic [REG_IDX_W-1:0] REG_SPARE_HI = 3'd7;

    typedef enum int {ZONE_MODERATE, ZONE_ANY, ZONE_EXTREME} t_zone_mode;

    typedef struct {
        t_coord left;
        t_coord top;
        t_dim   width;
        t_dim   height;
        t_dim   margin;
        logic   stay_inside;
    } t_zone;

    typedef struct {
        t_coord pos_x;
        t_coord pos_y;
        t_coord vel_x;
        t_coord vel_y;
        logic   collided;
        logic   inside_inset;
        logic   near_zone;
    } t_bounce;

    logic                   i_clk = 1'b0;
    logic                   i_rst_n;
    logic                   i_s_axis_tvalid;
    logic                   o_s_axis_tready;
    // [23:0] pos_x, [47:24] pos_y, [71:48] vel_x, [95:72] vel_y,
    // [119:96] prev_x, [143:120] prev_y
    logic [IN_DATA_W-1:0]   i_s_axis_tdata;
    logic                   o_m_axis_tvalid;
    logic                   i_m_axis_tready;
    // [23:0] out_pos_x, [47:24] out_pos_y, [71:48] out_vel_x, [95:72] out_vel_y
    logic [OUT_DATA_W-1:0]  o_m_axis_tdata;
    // [0] collided, [1] inside_inset, [2] near_zone
    logic [OUT_USER_W-1:0]  o_m_axis_tuser;
    logic                   psel;
    logic                   penable;
    logic                   pwrite;
    logic [APB_ADDR_W-1:0]  paddr;
    logic [APB_DATA_W-1:0]  pwdata;
    logic [APB_DATA_W-1:0]  prdata;
    logic                   pready;

    t_zone   zone;
    t_bounce pending_bounces[$];
    int      gap_pct;
    int      stall_pct;
    int      error_count;
    int      particles_sent;
    int      bounces_checked;
    int      reg_writes;
    int      zone_settings;
    int      quiet_cycles;

    rect_zone_particle_bounce i_dut (
        .i_clk           (i_clk),
        .i_rst_n         (i_rst_n),
        .i_s_axis_tvalid (i_s_axis_tvalid),
        .o_s_axis_tready (o_s_axis_tready),
        .i_s_axis_tdata  (i_s_axis_tdata),
        .o_m_axis_tvalid (o_m_axis_tvalid),
        .i_m_axis_tready (i_m_axis_tready),
        .o_m_axis_tdata  (o_m_axis_tdata),
        .o_m_axis_tuser  (o_m_axis_tuser),
        .psel            (psel),
        .penable         (penable),
        .pwrite          (pwrite),
        .paddr           (paddr),
        .pwdata          (pwdata),
        .prdata          (prdata),
        .pready          (pready)
    );

    always #5 i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Bounce predictor
    // ------------------------------------------------------------------
    function automatic logic inset_hit(input longint x, input longint y);
        longint lf;
        longint tp;
        longint wd;
        longint ht;
        longint m;
        lf = zone.left;
        tp = zone.top;
        wd = zone.width;
        ht = zone.height;
        m  = zone.margin;
        return x >= lf + m && x <= lf + wd - m && y >= tp + m && y <= tp + ht - m;
    endfunction

    function automatic longint clamp_to(input longint v, input longint lo, input longint hi);
        if (v < lo) begin
            return lo;
        end
        if (v > hi) begin
            return hi;
        end
        return v;
    endfunction

    // Squared distance to the closed rectangle, strictly below margin squared
    function automatic logic halo_hit(input longint x, input longint y);
        longint lf;
        longint tp;
        longint wd;
        longint ht;
        longint m;
        longint dx;
        longint dy;
        lf = zone.left;
        tp = zone.top;
        wd = zone.width;
        ht = zone.height;
        m  = zone.margin;
        dx = x - clamp_to(x, lf, lf + wd);
        dy = y - clamp_to(y, tp, tp + ht);
        return dx * dx + dy * dy < m * m;
    endfunction

    function automatic logic placement_ok(input longint x, input longint y);
        return zone.stay_inside ? inset_hit(x, y) : !halo_hit(x, y);
    endfunction

    function automatic t_coord negate_sat(input t_coord v);
        longint n;
        n = -longint'(v);
        if (n > 8388607) begin
            n = 8388607;
        end
        return t_coord'(n);
    endfunction

    function automatic t_bounce resolve_bounce(input t_particle p);
        t_bounce r;
        logic    ok;
        logic    x_ok;
        logic    y_ok;
        r.inside_inset = inset_hit(p.pos_x, p.pos_y);
        r.near_zone    = halo_hit(p.pos_x, p.pos_y);
        ok             = zone.stay_inside ? r.inside_inset : !r.near_zone;
        r.collided     = !ok;
        r.pos_x        = p.pos_x;
        r.pos_y        = p.pos_y;
        r.vel_x        = p.vel_x;
        r.vel_y        = p.vel_y;
        if (!ok) begin
            // Test each lone-axis move; revert the bad axes, or both if neither is bad
            x_ok = placement_ok(p.pos_x, p.prev_y);
            y_ok = placement_ok(p.prev_x, p.pos_y);
            if (!x_ok || y_ok) begin
                r.pos_x = p.prev_x;
                r.vel_x = negate_sat(p.vel_x);
            end
            if (!y_ok || x_ok) begin
                r.pos_y = p.prev_y;
                r.vel_y = negate_sat(p.vel_y);
            end
        end
        return r;
    endfunction

    // ------------------------------------------------------------------
    // Stimulus helpers
    // ------------------------------------------------------------------
    function automatic t_particle make_particle(input t_coord px, input t_coord py,
                                                input t_coord vx, input t_coord vy,
                                                input t_coord qx, input t_coord qy);
        t_particle p;
        p.pos_x  = px;
        p.pos_y  = py;
        p.vel_x  = vx;
        p.vel_y  = vy;
        p.prev_x = qx;
        p.prev_y = qy;
        return p;
    endfunction

    // Coordinate biased toward the span [lo, hi] and its margin bands
    function automatic t_coord pick_coord(input longint lo, input longint hi,
                                          input longint m);
        longint v;
        longint span;
        longint r;
        int     sel;
        sel = $urandom_range(99);
        if (sel < 15) begin
            return t_coord'($urandom);
        end
        if (sel < 20) begin
            return $urandom_range(1) ? COORD_MIN : COORD_MAX;
        end
        if (sel < 55) begin
            case ($urandom_range(5))
                0: v = lo;
                1: v = hi;
                2: v = lo + m;
                3: v = hi - m;
                4: v = lo - m;
                default: v = hi + m;
            endcase
            v = v + longint'($urandom_range(8)) - 4;
        end else begin
            span = hi - lo + 2 * m + 128;
            r    = longint'($urandom);
            v    = lo - m - 64 + r % span;
        end
        v = clamp_to(v, -8388608, 8388607);
        return t_coord'(v);
    endfunction

    function automatic t_coord pick_velocity();
        if ($urandom_range(9) == 0) begin
            return COORD_MIN;
        end
        return t_coord'($urandom);
    endfunction

    function automatic t_particle random_particle();
        t_particle p;
        longint    lx;
        longint    ly;
        longint    wd;
        longint    ht;
        longint    m;
        lx = zone.left;
        ly = zone.top;
        wd = zone.width;
        ht = zone.height;
        m  = zone.margin;
        // Mostly particles moving around the zone edges, some pure noise
        if ($urandom_range(99) < 15) begin
            return make_particle(t_coord'($urandom), t_coord'($urandom),
                                 t_coord'($urandom), t_coord'($urandom),
                                 t_coord'($urandom), t_coord'($urandom));
        end
        p.pos_x  = pick_coord(lx, lx + wd, m);
        p.pos_y  = pick_coord(ly, ly + ht, m);
        p.vel_x  = pick_velocity();
        p.vel_y  = pick_velocity();
        p.prev_x = pick_coord(lx, lx + wd, m);
        p.prev_y = pick_coord(ly, ly + ht, m);
        return p;
    endfunction

    // One particle request; tvalid stays high into the next request when no gap
    task automatic send_particle(input t_particle p);
        while ($urandom_range(99) < gap_pct) begin
            i_s_axis_tvalid <= 1'b0;
            @(posedge i_clk);
        end
        i_s_axis_tvalid <= 1'b1;
        i_s_axis_tdata  <= {p.prev_y, p.prev_x, p.vel_y, p.vel_x, p.pos_y, p.pos_x};
        pending_bounces.push_back(resolve_bounce(p));
        particles_sent++;
        do @(posedge i_clk); while (!o_s_axis_tready);
    endtask

    // Stop sending and wait for every outstanding result plus pipeline depth
    task automatic drain_pipeline();
        i_s_axis_tvalid <= 1'b0;
        while (pending_bounces.size() != 0) begin
            @(posedge i_clk);
        end
        repeat (NUM_STAGES) @(posedge i_clk);
    endtask

    task automatic write_zone_reg(input logic [REG_IDX_W-1:0] idx,
                                  input logic [APB_DATA_W-1:0] value);
        psel    <= 1'b1;
        penable <= 1'b0;
        pwrite  <= 1'b1;
        paddr   <= {idx, 2'b00};
        pwdata  <= value;
        @(posedge i_clk);
        penable <= 1'b1;
        do @(posedge i_clk); while (!pready);
        psel    <= 1'b0;
        penable <= 1'b0;
        case (idx)
            REG_ZONE_LEFT:   zone.left        = t_coord'(value[COORD_W-1:0]);
            REG_ZONE_TOP:    zone.top         = t_coord'(value[COORD_W-1:0]);
            REG_ZONE_WIDTH:  zone.width       = value[DIM_W-1:0];
            REG_ZONE_HEIGHT: zone.height      = value[DIM_W-1:0];
            REG_EDGE_MARGIN: zone.margin      = value[DIM_W-1:0];
            REG_STAY_INSIDE: zone.stay_inside = value[0];
            default: ;
        endcase
        reg_writes++;
        @(posedge i_clk);
    endtask

    // Full zone setup with random junk above each register's width
    task automatic set_zone(input t_coord left, input t_coord top, input t_dim width,
                            input t_dim height, input t_dim margin, input logic stay);
        logic [31:0] junk;
        drain_pipeline();
        junk = $urandom;
        write_zone_reg(REG_ZONE_LEFT,   {junk[31:24], left});
        write_zone_reg(REG_ZONE_TOP,    {junk[30:23], top});
        write_zone_reg(REG_ZONE_WIDTH,  {junk[31:23], width});
        write_zone_reg(REG_ZONE_HEIGHT, {junk[30:22], height});
        write_zone_reg(REG_EDGE_MARGIN, {junk[29:21], margin});
        write_zone_reg(REG_STAY_INSIDE, {junk[31:1], stay});
        zone_settings++;
    endtask

    task automatic set_random_zone(input t_zone_mode mode);
        t_coord lf;
        t_coord tp;
        t_dim   wd;
        t_dim   ht;
        t_dim   m;
        int     sel;
        case (mode)
            ZONE_MODERATE: begin
                lf  = t_coord'(int'($urandom_range(32'h100000)) - 32'h80000);
                tp  = t_coord'(int'($urandom_range(32'h100000)) - 32'h80000);
                wd  = t_dim'($urandom_range(32'h80000, 32'h100));
                ht  = t_dim'($urandom_range(32'h80000, 32'h100));
                sel = $urandom_range(99);
                if (sel < 10) begin
                    m = '0;
                end else if (sel < 20) begin
                    m = wd / 2 + t_dim'($urandom_range(256));
                end else begin
                    m = t_dim'($urandom_range((wd < ht ? wd : ht) / 4));
                end
            end
            ZONE_ANY: begin
                lf = t_coord'($urandom);
                tp = t_coord'($urandom);
                wd = t_dim'($urandom);
                ht = t_dim'($urandom);
                m  = t_dim'($urandom);
            end
            default: begin
                lf = $urandom_range(1) ? COORD_MIN : COORD_MAX;
                tp = $urandom_range(1) ? COORD_MIN : COORD_MAX;
                wd = $urandom_range(1) ? '0 : '1;
                ht = $urandom_range(1) ? '0 : '1;
                case ($urandom_range(2))
                    0: m = '0;
                    1: m = t_dim'(1);
                    default: m = '1;
                endcase
            end
        endcase
        set_zone(lf, tp, wd, ht, m, $urandom_range(1));
    endtask

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    // Reset zone: a point rectangle at the origin, stay-inside, no margin
    task automatic test_reset_defaults();
        send_particle(make_particle(0, 0, 0, 0, 0, 0));
        send_particle(make_particle(1, 0, 'h40, -'h40, 0, 0));
        send_particle(make_particle(COORD_MAX, COORD_MIN, COORD_MIN, COORD_MAX, 0, 0));
        drain_pipeline();
    endtask

    task automatic test_stay_inside();
        set_zone('h1000, 'h2000, 'h4000, 'h4000, 'h200, 1'b1);
        send_particle(make_particle('h3000, 'h3000, 'h100, -'h80, 'h2F00, 'h3000));
        send_particle(make_particle('h5000, 'h3000, 'h200, 'h40, 'h4D00, 'h3000));
        send_particle(make_particle('h3000, 'h1000, 'h10, -'h300, 'h3000, 'h2300));
        send_particle(make_particle('h5400, 'h7000, 'h300, 'h300, 'h4D00, 'h5D00));
        send_particle(make_particle('h5000, 'h3000, COORD_MIN, COORD_MIN, 'h4D00, 'h3000));
        // Closed bounds: exactly on the inset edge is valid, one step out is not
        send_particle(make_particle('h1200, 'h5E00, 'h1, 'h1, 'h1300, 'h5D00));
        send_particle(make_particle('h11FF, 'h3000, -'h1, 'h0, 'h1300, 'h3000));
        // Margin beyond half the rectangle leaves no valid position
        set_zone('h1000, 'h2000, 'h4000, 'h4000, 'h2100, 1'b1);
        send_particle(make_particle('h3000, 'h4000, 'h20, 'h30, 'h3000, 'h4000));
        send_particle(make_particle(COORD_MIN, COORD_MAX, COORD_MAX, COORD_MIN,
                                    COORD_MAX, COORD_MIN));
        drain_pipeline();
    endtask

    task automatic test_keep_out();
        // Zero margin: nothing is strictly closer than zero, all valid
        set_zone('h1000, 'h2000, 'h4000, 'h4000, 'h0, 1'b0);
        send_particle(make_particle('h3000, 'h3000, 'h100, 'h100, 'h0, 'h0));
        send_particle(make_particle('h1000, 'h2000, -'h100, 'h100, 'h0, 'h0));
        set_zone('h1000, 'h2000, 'h4000, 'h4000, 'h400, 1'b0);
        // Diagonal into the corner halo: both lone moves stay clear
        send_particle(make_particle('h0D80, 'h1D80, 'h180, 'h180, 'h0B00, 'h1B00));
        send_particle(make_particle('h0E00, 'h4000, 'h400, 'h0, 'h0A00, 'h4000));
        send_particle(make_particle('h3000, 'h6200, 'h0, -'h600, 'h3000, 'h6800));
        // Distance equal to the margin is not inside the halo
        send_particle(make_particle('h0C00, 'h4000, 'h10, 'h10, 'h0A00, 'h4000));
        send_particle(make_particle('h3000, 'h3000, 'h80, 'h900, 'h3000, 'h1800));
        send_particle(make_particle('h3000, 'h6200, 'h10, COORD_MIN, 'h3000, 'h6800));
        drain_pipeline();
    endtask

    // Junk above register widths and writes past the map must not disturb the zone
    task automatic test_register_masking();
        drain_pipeline();
        write_zone_reg(REG_ZONE_LEFT,   32'hAB_FFF000);
        write_zone_reg(REG_ZONE_TOP,    32'h5A_000800);
        write_zone_reg(REG_ZONE_WIDTH,  32'hFF_802000);
        write_zone_reg(REG_ZONE_HEIGHT, 32'h01_801800);
        write_zone_reg(REG_EDGE_MARGIN, 32'hFFFF_FFFF);
        write_zone_reg(REG_STAY_INSIDE, 32'hFFFF_FFFE);
        write_zone_reg(REG_SPARE_LO,    $urandom);
        write_zone_reg(REG_SPARE_HI,    $urandom);
        write_zone_reg(REG_EDGE_MARGIN, 32'hFF_800100);
        zone_settings++;
        send_particle(make_particle('h0000, 'h1000, 'h55, 'hAA, -'h2000, 'h1000));
        send_particle(make_particle(-'h1080, 'h1000, 'h7F, -'h7F, -'h1400, 'h1000));
        send_particle(make_particle('h1000, 'h2000, 'h1, 'h1, 'h0000, 'h0000));
        drain_pipeline();
    endtask

    task automatic test_random_traffic(input int sender_gap, input int receiver_stall,
                                       input int phase_no, input int per_zone,
                                       input bit with_pause);
        gap_pct   = sender_gap;
        stall_pct = receiver_stall;
        for (int z = 0; z < 3; z++) begin
            set_random_zone(t_zone_mode'((z + phase_no) % 3));
            for (int n = 0; n < per_zone; n++) begin
                if (with_pause && z == 1 && n == per_zone / 2) begin
                    drain_pipeline();
                end
                send_particle(random_particle());
            end
        end
        drain_pipeline();
    endtask

    // ------------------------------------------------------------------
    // Receiver stalls
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        i_m_axis_tready <= ($urandom_range(99) >= stall_pct);
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    task automatic check_field(input string name, input longint want, input longint got);
        if (want != got) begin
            $error("%s: expected %0d, got %0d", name, want, got);
            error_count++;
        end
    endtask

    always @(posedge i_clk) begin
        t_bounce want;
        if (i_rst_n && o_m_axis_tvalid && i_m_axis_tready) begin
            if (pending_bounces.size() == 0) begin
                $error("result with no request outstanding: tdata %h tuser %b",
                       o_m_axis_tdata, o_m_axis_tuser);
                error_count++;
            end else begin
                want = pending_bounces.pop_front();
                check_field("out_pos_x", want.pos_x, t_coord'(o_m_axis_tdata[23:0]));
                check_field("out_pos_y", want.pos_y, t_coord'(o_m_axis_tdata[47:24]));
                check_field("out_vel_x", want.vel_x, t_coord'(o_m_axis_tdata[71:48]));
                check_field("out_vel_y", want.vel_y, t_coord'(o_m_axis_tdata[95:72]));
                check_field("collided", want.collided, o_m_axis_tuser[0]);
                check_field("inside_inset", want.inside_inset, o_m_axis_tuser[1]);
                check_field("near_zone", want.near_zone, o_m_axis_tuser[2]);
                bounces_checked++;
            end
        end
    end

    // ------------------------------------------------------------------
    // Watchdog: cycles with no transfer on any port
    // ------------------------------------------------------------------
    always @(posedge i_clk) begin
        if (!i_rst_n || (i_s_axis_tvalid && o_s_axis_tready) ||
            (o_m_axis_tvalid && i_m_axis_tready) || (psel && penable && pwrite && pready)) begin
            quiet_cycles <= 0;
        end else if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("watchdog: no transfer for %0d cycles", quiet_cycles);
            $display("tb_rect_zone_particle_bounce: done, errors");
            $finish;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
        end
    end

    // ------------------------------------------------------------------
    // Sequence
    // ------------------------------------------------------------------
    initial begin
        i_rst_n          = 1'b0;
        i_s_axis_tvalid  = 1'b0;
        i_s_axis_tdata   = '0;
        i_m_axis_tready  = 1'b0;
        psel             = 1'b0;
        penable          = 1'b0;
        pwrite           = 1'b0;
        paddr            = '0;
        pwdata           = '0;
        quiet_cycles     = 0;
        gap_pct          = 0;
        stall_pct        = 0;
        error_count      = 0;
        particles_sent   = 0;
        bounces_checked  = 0;
        reg_writes       = 0;
        zone_settings    = 0;
        zone.left        = '0;
        zone.top         = '0;
        zone.width       = '0;
        zone.height      = '0;
        zone.margin      = '0;
        zone.stay_inside = 1'b1;

        repeat (6) @(posedge i_clk);
        i_rst_n <= 1'b1;
        @(posedge i_clk);

        test_reset_defaults();
        test_stay_inside();
        test_keep_out();
        test_register_masking();
        test_random_traffic(0,  0,  0, 105, 1'b0);
        test_random_traffic(73, 0,  1, 105, 1'b0);
        test_random_traffic(0,  73, 2, 105, 1'b1);
        test_random_traffic(22, 22, 3, 105, 1'b0);

        drain_pipeline();
        repeat (2 * NUM_STAGES) @(posedge i_clk);

        $display("Summary: %0d particles, %0d results compared, %0d zone settings, %0d reg writes",
                 particles_sent, bounces_checked, zone_settings, reg_writes);
        $display("Summary: stay-inside and keep-out zones, edge/empty-inset cases, four idle mixes");
        if (error_count == 0) begin
            $display("tb_rect_zone_particle_bounce: done, clean");
        end else begin
            $display("tb_rect_zone_particle_bounce: done, errors");
        end
        $finish;
    end

endmodule
